// ===== hw/rtl/additive_sawtooth_synth_assert.svh =====
// Assertion helpers for the additive sawtooth synthesizer.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ADDITIVE_SAWTOOTH_SYNTH_ASSERT_SVH
`define ADDITIVE_SAWTOOTH_SYNTH_ASSERT_SVH
`ifndef SYNTHESIS
`define ASYN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASYN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASYN_ASSERT_IMP(lbl, ante, cons, msg)
`define ASYN_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/asyn_pkg.sv =====
`default_nettype none
package asyn_pkg;

  localparam int MAX_HARMONICS   = 64;
  localparam int SINE_TABLE_BITS = 10;

  localparam logic [1:0] CFG_PHASE_INC  = 2'd0;
  localparam logic [1:0] CFG_HARM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_VOLUME     = 2'd2;

  typedef struct packed {
    logic valid;
    logic neg;
  } asyn_tag_t;

  // Quarter-wave polynomial sine magnitude, Q1.15.
  function automatic logic [14:0] sine_mag(input int unsigned idx, input int unsigned bits);
    int unsigned qbits;
    int unsigned quad;
    int unsigned r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    qbits = bits - 2;
    quad  = (idx >> qbits) & 3;
    r     = idx & ((1 << qbits) - 1);
    x     = 64'(r) << (16 - qbits);
    if ((quad & 1) != 0) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = (64'd4926 * x2) >> 16;
    t  = 64'd42334 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    y  = (t * x) >> 16;
    y  = (y + 64'd1) >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return y[14:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/additive_sawtooth_synth.sv =====
// Each input beat sums harmonics 1 to N, N = min(limit, MaxHarmonics) - 1, issued one
// per cycle through the sine ROM read and two registered multiplies, then drains the
// term pipeline and registers the saturated sum (zero, straight away, when limit is
// below 2). No new input beat is taken until the result passes the output stall.
// Reset (synchronous) clears the phase, sets limit 1 and gain 32767.
`default_nettype none
module additive_sawtooth_synth
  import asyn_pkg::*;
#(
  parameter int MaxHarmonics  = MAX_HARMONICS,
  parameter int SineTableBits = SINE_TABLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      sample
);

  localparam int HW   = $clog2(MaxHarmonics);
  localparam int SumW = $clog2(MaxHarmonics) + 16;
  localparam logic signed [SumW-1:0] SatHi = SumW'(32767);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-32768);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [31:0]            phase_increment;
  logic [6:0]             harmonic_limit;
  logic [14:0]            volume_gain;
  logic [31:0]            phase_acc;
  logic [31:0]            base_phase;
  logic [31:0]            harm_phase;
  logic [HW-1:0]          harm;
  logic [HW-1:0]          last_harm;
  logic signed [SumW-1:0] sum;

  logic [8:0]             lim_ext;
  logic [8:0]             lim_clamp;
  logic [31:0]            start_phase;
  logic signed [SumW-1:0] term_ext;
  logic signed [15:0]     sat_sum;
  logic                   in_beat;

  asyn_tag_t              issue;
  asyn_tag_t              term_tag;
  logic [14:0]            term_mag;
  logic [14:0]            rom_data;
  logic                   term_busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;

  assign lim_ext     = {2'b00, harmonic_limit};
  assign lim_clamp   = (lim_ext > 9'(MaxHarmonics)) ? 9'(MaxHarmonics) : lim_ext;
  assign start_phase = restart ? 32'd0 : phase_acc;

  assign issue.valid = (state == ST_RUN);
  assign issue.neg   = harm[0] ^ harm_phase[31];

  assign term_ext = signed'({{(SumW-15){1'b0}}, term_mag});

  always_comb begin
    if (sum > SatHi) begin
      sat_sum = 16'sh7fff;
    end else if (sum < SatLo) begin
      sat_sum = -16'sh8000;
    end else begin
      sat_sum = sum[15:0];
    end
  end

  asyn_sine_rom #(
    .SineTableBits(SineTableBits)
  ) u_rom (
    .clk    (clk),
    .addr   (harm_phase[31 -: SineTableBits]),
    .rd_data(rom_data)
  );

  asyn_term #(
    .MaxHarmonics(MaxHarmonics)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .issue_h (harm),
    .rom_data(rom_data),
    .gain    (volume_gain),
    .term_tag(term_tag),
    .term_mag(term_mag),
    .busy    (term_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase_increment <= '0;
      harmonic_limit  <= 7'd1;
      volume_gain     <= 15'd32767;
      phase_acc       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_INC:  phase_increment <= cfg_data;
          CFG_HARM_LIMIT: harmonic_limit  <= cfg_data[6:0];
          CFG_VOLUME:     volume_gain     <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      if (term_tag.valid) begin
        sum <= term_tag.neg ? sum - term_ext : sum + term_ext;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            base_phase <= start_phase;
            harm_phase <= start_phase;
            phase_acc  <= start_phase + phase_increment;
            harm       <= HW'(1);
            last_harm  <= HW'(lim_clamp - 9'd1);
            sum        <= '0;
            state      <= (lim_clamp >= 9'd2) ? ST_RUN : ST_FINISH;
          end
        end
        ST_RUN: begin
          harm_phase <= harm_phase + base_phase;
          harm       <= harm + HW'(1);
          if (harm == last_harm) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!term_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            sample    <= sat_sum;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "additive_sawtooth_synth_assert.svh"

  `ASYN_ASSERT_NXT(a_busy_after_beat, in_beat, in_stall, "input beat did not start work")
  `ASYN_ASSERT_IMP(a_term_in_work, term_tag.valid, state == ST_DRAIN || state == ST_RUN, "term outside work")
  `ASYN_ASSERT_IMP(a_out_from_finish, $rose(out_valid), $past(state) == ST_FINISH, "result without finish")

endmodule
`default_nettype wire

// ===== hw/rtl/asyn_sine_rom.sv =====
`default_nettype none
module asyn_sine_rom
  import asyn_pkg::*;
#(
  parameter int SineTableBits = SINE_TABLE_BITS
) (
  input  wire logic                     clk,
  input  wire logic [SineTableBits-1:0] addr,
  output logic      [14:0]              rd_data
);

  localparam int Depth = 1 << SineTableBits;

  logic [14:0] rom [Depth];

  for (genvar gi = 0; gi < Depth; gi++) begin : g_rom
    assign rom[gi] = sine_mag(gi, SineTableBits);
  end

  always_ff @(posedge clk) begin
    rd_data <= rom[addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/asyn_term.sv =====
`default_nettype none
module asyn_term
  import asyn_pkg::*;
#(
  parameter int MaxHarmonics = MAX_HARMONICS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire asyn_tag_t                       issue,
  input  wire logic [$clog2(MaxHarmonics)-1:0] issue_h,
  input  wire logic [14:0]                     rom_data,
  input  wire logic [14:0]                     gain,
  output asyn_tag_t                            term_tag,
  output logic      [14:0]                     term_mag,
  output logic                                 busy
);

  logic [14:0] amp_tab [MaxHarmonics];

  for (genvar gi = 0; gi < MaxHarmonics; gi++) begin : g_amp
    localparam logic [14:0] AmpVal = 15'(32767 / ((gi == 0) ? 1 : gi));
    assign amp_tab[gi] = AmpVal;
  end

  asyn_tag_t   s1_tag;
  asyn_tag_t   s2_tag;
  logic [14:0] s1_amp;
  logic [14:0] s2_mag;
  logic [29:0] amp_prod;
  logic [29:0] gain_prod;

  assign amp_prod  = 30'(s1_amp) * 30'(rom_data);
  assign gain_prod = 30'(s2_mag) * 30'(gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag   <= '0;
      s2_tag   <= '0;
      term_tag <= '0;
    end else begin
      s1_tag   <= issue;
      s2_tag   <= s1_tag;
      term_tag <= s2_tag;
    end
    s1_amp   <= amp_tab[issue_h];
    s2_mag   <= amp_prod[29:15];
    term_mag <= gain_prod[29:15];
  end

  assign busy = s1_tag.valid | s2_tag.valid | term_tag.valid;

endmodule
`default_nettype wire

// ===== tb/sawtooth_checker.sv =====
`default_nettype none
module sawtooth_checker
  import asyn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               restart,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] sample,
  output int                      mismatches,
  output int                      outstanding
);

  logic [31:0]        phase_step = '0;
  logic [6:0]         harm_limit = 7'd1;
  logic [14:0]        gain = 15'h7FFF;
  logic [31:0]        osc_phase = '0;
  logic signed [15:0] pending_samples[$];
  int                 fails = 0;

  // Magnitude of the Q1.15 sine at a table index; sign comes from the top index bit.
  function automatic longint unsigned sine_magnitude(input int unsigned idx);
    int unsigned       qbits;
    int unsigned       quad;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint unsigned   y;
    qbits = SINE_TABLE_BITS - 2;
    quad  = (idx >> qbits) & 3;
    x     = 64'(idx & ((32'd1 << qbits) - 1)) << (16 - qbits);
    if (quad[0]) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = (64'd4926 * x2) >> 16;
    t  = 64'd42334 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    y  = (t * x) >> 16;
    y  = (y + 64'd1) >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return y;
  endfunction

  // Sum the harmonics at the current phase, then advance the phase.
  function automatic logic signed [15:0] synth_sample(input logic restart_bit);
    logic [31:0]     ph;
    logic [31:0]     hp;
    int unsigned     lim;
    int unsigned     h;
    int unsigned     idx;
    longint unsigned mag;
    longint          acc;
    logic            flip;
    if (restart_bit) begin
      osc_phase = '0;
    end
    ph  = osc_phase;
    lim = 32'(harm_limit);
    if (lim > MAX_HARMONICS) begin
      lim = MAX_HARMONICS;
    end
    acc = 0;
    for (h = 1; h < lim; h++) begin
      hp   = 32'(64'(h) * 64'(ph));
      idx  = hp >> (32 - SINE_TABLE_BITS);
      mag  = (64'(32767 / h) * sine_magnitude(idx)) >> 15;
      mag  = (mag * 64'(gain)) >> 15;
      flip = h[0] ^ idx[SINE_TABLE_BITS-1];
      if (flip) begin
        acc -= longint'(mag);
      end else begin
        acc += longint'(mag);
      end
    end
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < -32768) begin
      acc = -32768;
    end
    osc_phase = ph + phase_step;
    return 16'(acc);
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      phase_step = '0;
      harm_limit = 7'd1;
      gain       = 15'h7FFF;
      osc_phase  = '0;
      pending_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected sample beat: got %0d", sample);
          end
          fails++;
        end else begin
          want = pending_samples.pop_front();
          if (sample !== want) begin
            if (fails < 10) begin
              $display("sample mismatch: expected %0d got %0d", want, sample);
            end
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_INC:  phase_step = cfg_data;
          CFG_HARM_LIMIT: harm_limit = cfg_data[6:0];
          CFG_VOLUME:     gain       = cfg_data[14:0];
          default:        ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_samples.push_back(synth_sample(restart));
      end
    end
    mismatches  <= fails;
    outstanding <= pending_samples.size();
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top
  import asyn_pkg::*;
;

  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = MAX_HARMONICS + 8;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES = 12;
  localparam int BEATS_PER_PHASE = 155;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_PHASE_INC;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample;
  int                 fail_total;
  int                 waiting;
  int                 pressure_req = 0;
  int                 pressure_seen = 0;
  logic               steady = 1'b0;

  additive_sawtooth_synth dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
  );

  sawtooth_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .mismatches  (fail_total),
    .outstanding (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic idle_draw();
    return !steady && ($urandom_range(0, 99) < 31);
  endfunction

  task automatic send_beat(input logic restart_bit);
    cfg_valid <= 1'b0;
    while (idle_draw()) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config(input bit write_all);
    logic [31:0] data;
    if (write_all || $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 5))
        0:       data = '0;
        1:       data = 32'hFFFF_FFFF;
        2:       data = $urandom_range(0, 32'h000F_FFFF);
        default: data = $urandom;
      endcase
      cfg_write(CFG_PHASE_INC, data);
    end
    if (write_all || $urandom_range(0, 4) != 0) begin
      data = $urandom;
      case ($urandom_range(0, 5))
        0:       data[6:0] = 7'($urandom_range(0, 1));
        1:       data[6:0] = 7'($urandom_range(MAX_HARMONICS, 127));
        default: data[6:0] = 7'($urandom_range(2, MAX_HARMONICS));
      endcase
      cfg_write(CFG_HARM_LIMIT, data);
    end
    if (write_all || $urandom_range(0, 4) != 0) begin
      data = $urandom;
      case ($urandom_range(0, 3))
        0:       data[14:0] = '0;
        1:       data[14:0] = 15'h7FFF;
        default: data[14:0] = 15'($urandom_range(0, 15'h7FFF));
      endcase
      cfg_write(CFG_VOLUME, data);
    end
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_NONE, $urandom);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= idle_draw();
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(1'b0);
    send_beat(1'b1);

    drain_idle();
    cfg_write(CFG_PHASE_INC, 32'h7E00_0000);
    cfg_write(CFG_HARM_LIMIT, 32'd64);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);

    drain_idle();
    cfg_write(CFG_HARM_LIMIT, 32'hFFFF_FFFF);
    cfg_write(CFG_PHASE_INC, 32'hFFFF_FFFF);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);

    drain_idle();
    cfg_write(CFG_VOLUME, 32'h0000_0000);
    repeat (2) send_beat(1'b0);

    drain_idle();
    cfg_write(CFG_VOLUME, 32'hFFFF_FFFF);
    cfg_write(CFG_HARM_LIMIT, 32'd0);
    send_beat(1'b0);

    drain_idle();
    cfg_write(CFG_HARM_LIMIT, 32'd2);
    cfg_write(CFG_PHASE_INC, 32'h4000_0000);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);

    drain_idle();
    cfg_write(CFG_NONE, $urandom);
    cfg_write(CFG_HARM_LIMIT, 32'd65);
    send_beat(1'b1);
    send_beat(1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_idle();
      random_config(ph == 0);
      steady <= (ph == 4);
      if (ph == 2) begin
        pressure_req <= pressure_req + 1;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        send_beat($urandom_range(0, 9) == 0);
      end
    end

    drain_idle();
    if (fail_total == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== additive_sawtooth_synth.f =====
+incdir+hw/rtl
hw/rtl/asyn_pkg.sv
hw/rtl/asyn_sine_rom.sv
hw/rtl/asyn_term.sv
hw/rtl/additive_sawtooth_synth.sv
tb/sawtooth_checker.sv
tb/tb_top.sv
